// ===== rtl/cfd_pkg.sv =====
// ---------------------------------------------------------------------------
// cfd_pkg
// Types, constants and the CRC-16/CCITT-FALSE byte update for the deframer.
// ---------------------------------------------------------------------------
package cfd_pkg;

   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'h1021;
   localparam logic [15:0] CRC_TOP   = 16'h8000;
   localparam logic [8:0]  COUNT_MAX = 9'd260;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_SHORT     = 3'd1,
      STATUS_BAD_SYNC  = 3'd2,
      STATUS_BAD_LEN   = 3'd3,
      STATUS_BAD_CRC   = 3'd4
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      status_type status;
      logic [7:0] version;
      logic [7:0] command;
      logic [7:0] channel;
      logic [7:0] body_len;
   } result_type;

   typedef struct packed {
      logic load;
      logic ready;
   } stage_ctrl_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/crc16_frame_deframer.sv =====
// ---------------------------------------------------------------------------
// crc16_frame_deframer
// Length-prefixed frame checker with CRC-16/CCITT-FALSE; forwards payload
// bytes and gives one verdict per buffer.
//
//   channel  dir  payload
//   req_     in   tdata[7:0] data_byte, tlast end_of_buffer
//   rsp_     out  tuser kind, tdata payload/status/header fields
//   csr_     in   csr_wdata sync_value, written when csr_we is high
//
// One byte per cycle sustained while rsp_tready stays high; an accepted byte
// sits in the input register, and its result, if it has one, leaves from the
// result register, where rsp_tvalid marks it.
// Synchronous reset clears frame state and sync_value to zero, CRC to FFFF.
// A stall on rsp_tready holds the result and backs up into req_tready.
// ---------------------------------------------------------------------------
module crc16_frame_deframer import cfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] payload_byte, [10:8] status, [18:11] version, [26:19] command,
   // [34:27] channel, [42:35] body_len, [47:43] zero
   output logic [47:0] rsp_tdata,
   output logic        rsp_tuser    // kind
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_data_ff;
   logic           in_last_ff;
   logic           advance;
   logic           core_valid;
   result_type     core_result;
   stage_ctrl_type out_ctrl;
   logic           out_valid;
   result_type     out_result;

   assign advance     = in_valid_ff && out_ctrl.ready;
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   cfd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .step         (advance),
      .data_byte    (in_data_ff),
      .last         (in_last_ff),
      .result_valid (core_valid),
      .result       (core_result)
   );

   cfd_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (in_valid_ff && core_valid),
      .load_result (core_result),
      .rsp_tready  (rsp_tready),
      .ctrl        (out_ctrl),
      .out_valid   (out_valid),
      .out_result  (out_result)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tuser  = out_result.kind;
   assign rsp_tdata  = {5'd0, out_result.body_len, out_result.channel,
                        out_result.command, out_result.version,
                        out_result.status, out_result.payload_byte};

   a_verdict_follows_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> rsp_tvalid && rsp_tuser)
      else $error("last byte did not yield a verdict");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[10:8] <= 3'd4)
      else $error("verdict status out of range");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[47:8] == 40'd0)
      else $error("payload item carries verdict fields");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input register empty but not ready");

endmodule

// ===== rtl/cfd_core.sv =====
// ---------------------------------------------------------------------------
// cfd_core
// Frame state, running CRC and result formation for one byte per step.
// ---------------------------------------------------------------------------
module cfd_core import cfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   input  logic       step,
   input  logic [7:0] data_byte,
   input  logic       last,
   output logic       result_valid,
   output result_type result
);

   logic [7:0]  sync_value_ff;
   logic [8:0]  count_ff,     count_in;
   logic        sync_seen_ff, sync_seen_in;
   logic [7:0]  length_ff,    length_in;
   logic [15:0] crc_ff,       crc_in;
   logic [7:0]  version_ff,   version_in;
   logic [7:0]  command_ff,   command_in;
   logic [7:0]  channel_ff,   channel_in;
   logic [7:0]  crc_low_ff,   crc_low_in;

   logic [8:0]  crc_end;
   logic [8:0]  len_plus4;
   logic        is_payload;
   status_type  status;

   always_comb begin
      crc_end      = {1'b0, length_ff} + 9'd2;
      sync_seen_in = sync_seen_ff;
      length_in    = length_ff;
      crc_in       = crc_ff;
      version_in   = version_ff;
      command_in   = command_ff;
      channel_in   = channel_ff;
      crc_low_in   = crc_low_ff;
      is_payload   = 1'b0;

      if (count_ff == 9'd0) begin
         sync_seen_in = (data_byte == sync_value_ff);
      end else if (count_ff == 9'd1) begin
         length_in = data_byte;
      end else begin
         if (count_ff < crc_end) begin
            crc_in = crc_byte(crc_ff, data_byte);
         end else if (count_ff == crc_end) begin
            crc_low_in = data_byte;
         end
         if (count_ff == 9'd2) begin
            version_in = data_byte;
         end else if (count_ff == 9'd3) begin
            command_in = data_byte;
         end else if (count_ff == 9'd4) begin
            channel_in = data_byte;
         end else if (count_ff < crc_end) begin
            is_payload = 1'b1;
         end
      end

      count_in  = (count_ff < COUNT_MAX) ? count_ff + 9'd1 : count_ff;
      len_plus4 = {1'b0, length_in} + 9'd4;

      if (count_in < 9'd4) begin
         status = STATUS_SHORT;
      end else if (!sync_seen_in) begin
         status = STATUS_BAD_SYNC;
      end else if (length_in < 8'd3 || count_in != len_plus4) begin
         status = STATUS_BAD_LEN;
      end else if ({data_byte, crc_low_in} != crc_in) begin
         status = STATUS_BAD_CRC;
      end else begin
         status = STATUS_OK;
      end

      result = '0;
      if (last) begin
         result.kind     = KIND_VERDICT;
         result.status   = status;
         result.version  = version_in;
         result.command  = command_in;
         result.channel  = channel_in;
         result.body_len = (status == STATUS_OK) ? length_in - 8'd3 : 8'd0;
      end else begin
         result.kind         = KIND_PAYLOAD;
         result.payload_byte = data_byte;
         result.status       = STATUS_OK;
      end
      result_valid = last || (is_payload && sync_seen_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_value_ff <= 8'd0;
      end else if (csr_we) begin
         sync_value_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         count_ff     <= 9'd0;
         sync_seen_ff <= 1'b0;
         length_ff    <= 8'd0;
         crc_ff       <= CRC_INIT;
         version_ff   <= 8'd0;
         command_ff   <= 8'd0;
         channel_ff   <= 8'd0;
         crc_low_ff   <= 8'd0;
      end else if (step) begin
         count_ff     <= count_in;
         sync_seen_ff <= sync_seen_in;
         length_ff    <= length_in;
         crc_ff       <= crc_in;
         version_ff   <= version_in;
         command_ff   <= command_in;
         channel_ff   <= channel_in;
         crc_low_ff   <= crc_low_in;
      end
   end

endmodule

// ===== rtl/cfd_out_stage.sv =====
// ---------------------------------------------------------------------------
// cfd_out_stage
// Result register holding one item until the downstream side takes it.
// ---------------------------------------------------------------------------
module cfd_out_stage import cfd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           load_valid,
   input  result_type     load_result,
   input  logic           rsp_tready,
   output stage_ctrl_type ctrl,
   output logic           out_valid,
   output result_type     out_result
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   always_comb begin
      ctrl.ready = !valid_ff || rsp_tready;
      ctrl.load  = ctrl.ready && load_valid;
      if (ctrl.ready) begin
         valid_in = load_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         result_ff <= load_result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb - self-checking bench for crc16_frame_deframer
// Drives byte buffers (directed frames, then random well-formed, corrupted,
// truncated, overlong and noise buffers) under the reset sync value and five
// written sync values. Each accepted byte runs through a local deframer model.
// Payload items and verdicts are checked in order against the model's output.
// ----------------------------------------------------------------------------
module tb import cfd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_ITEMS    = 40;

   // tdata layout, MSB first as declared
   typedef struct packed {
      logic [4:0] pad;
      logic [7:0] plen;
      logic [7:0] chn;
      logic [7:0] cmd;
      logic [7:0] ver;
      status_type st;
      logic [7:0] pbyte;
   } rsp_word_type;

   typedef struct packed {
      kind_type     kind;
      rsp_word_type w;
   } out_rec_type;

   typedef enum logic [1:0] {
      FILL_LIT,
      FILL_CRC_LO,
      FILL_CRC_HI
   } fill_type;

   typedef struct {
      fill_type   fill;
      logic [7:0] val;
      logic       last;
      bit         typed;
      status_type st;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [7:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;   // end_of_buffer
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // [7:0] payload_byte, [10:8] status, [18:11] version,
                             // [26:19] command, [34:27] channel, [42:35] body_len
   logic        rsp_tuser;   // kind

   // deframer model state
   logic [7:0]  p_sync;
   logic [8:0]  p_count;
   bit          p_seen;
   logic [7:0]  p_len;
   logic [15:0] p_crc;
   logic [7:0]  p_ver;
   logic [7:0]  p_cmd;
   logic [7:0]  p_chn;
   logic [7:0]  p_crc_lo;

   out_rec_type  rsp_due[$];
   logic [7:0]   frame_q[$];
   stim_row_type dir_rows[0:24];
   int           mismatches;
   int           idle_cycles;
   bit           hold_long_req;
   bit           burst_mode;

   crc16_frame_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 7; i >= 0; i--) begin
         fb = r[15] ^ d[i];
         r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   function automatic void clear_frame();
      p_count  = '0;
      p_seen   = 1'b0;
      p_len    = '0;
      p_crc    = CRC_INIT;
      p_ver    = '0;
      p_cmd    = '0;
      p_chn    = '0;
      p_crc_lo = '0;
   endfunction

   task automatic deframe_byte(input logic [7:0] b, input logic l,
                               output bit has, output out_rec_type res);
      logic [8:0] idx;
      logic [8:0] crc_end;
      logic [8:0] total;
      bit         fwd;
      idx     = p_count;
      crc_end = 9'd2 + {1'b0, p_len};
      fwd     = 1'b0;
      has     = 1'b0;
      res     = '0;
      if (idx == 9'd0) begin
         p_seen = (b == p_sync);
      end else if (idx == 9'd1) begin
         p_len = b;
      end else begin
         if (idx < crc_end) begin
            p_crc = crc16_next(p_crc, b);
         end else if (idx == crc_end) begin
            p_crc_lo = b;
         end
         if (idx == 9'd2) begin
            p_ver = b;
         end else if (idx == 9'd3) begin
            p_cmd = b;
         end else if (idx == 9'd4) begin
            p_chn = b;
         end else if (idx < crc_end) begin
            fwd = 1'b1;
         end
      end
      if (p_count < COUNT_MAX) p_count = p_count + 9'd1;
      if (!l) begin
         has         = fwd && p_seen;
         res.kind    = KIND_PAYLOAD;
         res.w.pbyte = b;
      end else begin
         total    = p_count;
         has      = 1'b1;
         res.kind = KIND_VERDICT;
         if (total < 9'd4) begin
            res.w.st = STATUS_SHORT;
         end else if (!p_seen) begin
            res.w.st = STATUS_BAD_SYNC;
         end else if (p_len < 8'd3 || total != {1'b0, p_len} + 9'd4) begin
            res.w.st = STATUS_BAD_LEN;
         end else if ({b, p_crc_lo} != p_crc) begin
            res.w.st = STATUS_BAD_CRC;
         end else begin
            res.w.st   = STATUS_OK;
            res.w.plen = p_len - 8'd3;
         end
         res.w.ver = p_ver;
         res.w.cmd = p_cmd;
         res.w.chn = p_chn;
         clear_frame();
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input logic l,
                            input bit typed, input status_type st);
      int          gap;
      int          r;
      bit          has;
      out_rec_type res;
      r   = $urandom_range(0, 99);
      gap = 0;
      if (!burst_mode) begin
         if (r >= 95) begin
            gap = $urandom_range(8, 30);
         end else if (r >= 65) begin
            gap = $urandom_range(1, 3);
         end
      end
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      deframe_byte(b, l, has, res);
      if (has) begin
         if (typed) begin
            res.w.st   = st;
            res.w.plen = '0;
         end
         rsp_due.push_back(res);
      end
   endtask

   task automatic send_buffer();
      burst_mode = ($urandom_range(0, 3) == 0);
      foreach (frame_q[i]) push_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, STATUS_OK);
   endtask

   task automatic put_good(input int len);
      logic [15:0] c;
      logic [7:0]  d;
      c       = CRC_INIT;
      frame_q = {};
      frame_q.push_back(p_sync);
      frame_q.push_back(8'(len));
      repeat (len) begin
         d = 8'($urandom);
         c = crc16_next(c, d);
         frame_q.push_back(d);
      end
      frame_q.push_back(c[7:0]);
      frame_q.push_back(c[15:8]);
   endtask

   task automatic build_random_buffer();
      int r;
      int len;
      int n;
      int pos;
      r   = $urandom_range(0, 99);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12);
      if (r < 60) begin
         put_good(len);
      end else if (r < 70) begin
         put_good(len);
         pos = $urandom_range(2, frame_q.size() - 1);
         frame_q[pos] = frame_q[pos] ^ 8'(1 << $urandom_range(0, 7));
      end else if (r < 78) begin
         put_good(len);
         frame_q[0] = frame_q[0] ^ 8'($urandom_range(1, 255));
      end else if (r < 88) begin
         put_good(len);
         n = $urandom_range(1, 3);
         if ($urandom_range(0, 1) == 1) begin
            repeat (n) frame_q.push_back(8'($urandom));
         end else begin
            repeat (n) void'(frame_q.pop_back());
         end
      end else if (r < 92) begin
         frame_q = {};
         frame_q.push_back(p_sync);
         frame_q.push_back(8'($urandom_range(0, 2)));
         repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom));
      end else begin
         frame_q = {};
         repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
      end
   endtask

   task automatic set_sync(input logic [7:0] v);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      p_sync = v;
   endtask

   task automatic field_check(input string name, input logic [7:0] e, input logic [7:0] g);
      if (g !== e) begin
         mismatches++;
         $display("%0t: %s expected %h got %h", $time, name, e, g);
      end
   endtask

   task automatic check_rsp(input logic k, input rsp_word_type w);
      out_rec_type e;
      if (rsp_due.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected item kind %0d data %h", $time, k, w);
      end else begin
         e = rsp_due.pop_front();
         field_check("kind", 8'(e.kind), 8'(k));
         field_check("payload_byte", e.w.pbyte, w.pbyte);
         field_check("status", 8'(e.w.st), 8'(w.st));
         field_check("version", e.w.ver, w.ver);
         field_check("command", e.w.cmd, w.cmd);
         field_check("channel", e.w.chn, w.chn);
         field_check("body_len", e.w.plen, w.plen);
         field_check("pad", 8'(e.w.pad), 8'(w.pad));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_rsp(rsp_tuser, rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin
      int stall_left;
      int calm_left;
      int r;
      rsp_tready = 1'b0;
      stall_left = 0;
      calm_left  = 0;
      forever begin
         @(negedge clock);
         r = $urandom_range(0, 99);
         if (hold_long_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_long_req = 1'b0;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_tready <= 1'b1;
         end else if (r < 2) begin
            calm_left = $urandom_range(50, 150);
            rsp_tready <= 1'b1;
         end else if (r < 5) begin
            stall_left = $urandom_range(10, 40);
            rsp_tready <= 1'b0;
         end else if (r < 25) begin
            stall_left = $urandom_range(0, 2);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int         sent;
      logic [7:0] b;
      logic [7:0] sv;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      mismatches    = 0;
      hold_long_req = 1'b0;
      burst_mode    = 1'b0;
      p_sync        = '0;
      clear_frame();

      // sync is zero out of reset
      dir_rows = '{
         '{FILL_LIT,    8'h00, 1'b1, 1'b1, STATUS_SHORT},
         '{FILL_LIT,    8'hFF, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'h03, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'hAA, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'h55, 1'b1, 1'b1, STATUS_BAD_SYNC},
         '{FILL_LIT,    8'h00, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'h02, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'h01, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'h02, 1'b1, 1'b1, STATUS_BAD_LEN},
         '{FILL_LIT,    8'h00, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'h03, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'h12, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'h34, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'h56, 1'b0, 1'b0, STATUS_OK},
         '{FILL_CRC_LO, 8'h00, 1'b0, 1'b0, STATUS_OK},
         '{FILL_CRC_HI, 8'h00, 1'b1, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'h00, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'h05, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'hFF, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'h00, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'hFF, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'h00, 1'b0, 1'b0, STATUS_OK},
         '{FILL_LIT,    8'hFF, 1'b0, 1'b0, STATUS_OK},
         '{FILL_CRC_LO, 8'h00, 1'b0, 1'b0, STATUS_OK},
         '{FILL_CRC_HI, 8'h00, 1'b1, 1'b0, STATUS_OK}
      };

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         case (dir_rows[i].fill)
            FILL_CRC_LO: b = p_crc[7:0];
            FILL_CRC_HI: b = p_crc[15:8];
            default:     b = dir_rows[i].val;
         endcase
         push_byte(b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].st);
      end

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0:       sv = 8'hFF;
            1:       sv = 8'h00;
            4:       sv = 8'h80;
            default: sv = 8'($urandom);
         endcase
         set_sync(sv);
         if (ph == 2) hold_long_req = 1'b1;
         if (ph == 0) begin
            put_good(255);
            send_buffer();
         end
         if (ph == 3) begin
            // overlong: byte count saturates
            put_good(255);
            repeat (3) frame_q.push_back(8'($urandom));
            send_buffer();
         end
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_random_buffer();
            sent += frame_q.size();
            send_buffer();
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && rsp_due.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
